// ===== hdl/mqs_pkg.sv =====
// shared types and constants of the multilevel queue scheduler
package mqs_pkg;

	localparam int LEVELS = 4;
	localparam int LVL_W = 2;

	// register indexes of the configuration port
	localparam logic REG_QUANTUM = 1'b0;
	localparam logic REG_BUDGET = 1'b1;

	localparam logic [15:0] RESET_QUANTUM = 16'd4;
	localparam logic [5:0] RESET_BUDGET = 6'd20;

	// opcodes of an input transaction
	localparam logic OP_SUBMIT = 1'b0;
	localparam logic OP_RUN = 1'b1;

	// result kinds
	localparam logic [2:0] KIND_ACCEPTED = 3'd0;
	localparam logic [2:0] KIND_BAD_LEVEL = 3'd1;
	localparam logic [2:0] KIND_QUEUE_FULL = 3'd2;
	localparam logic [2:0] KIND_ZERO_BURST = 3'd3;
	localparam logic [2:0] KIND_COMPLETED = 3'd4;
	localparam logic [2:0] KIND_SLICE_END = 3'd5;

	// one queued job
	typedef struct packed {
		logic [7:0] id;
		logic [15:0] burst;
		logic [15:0] rem;
	} ent_t;

endpackage

// ===== hdl/multilevel_queue_scheduler_unit.sv =====
// Four-level job scheduler: input channel s_*, result channel m_*, config port cfg_*.
// Usage: s_tuser carries the opcode (submit or run), s_tdata the job fields.
// A submit returns one result (accepted or a reject code) once the output register is free.
// A run picks the next non-empty level from next_level onward and serves it
// with slice_budget time units; it returns one completion transaction per
// finished job and ends with one slice-end transaction marked by m_tlast.
// Each run step reads the front job (states LOOP, FRONT, RUN, and DONE for a completion);
// levels 1 and 2 first scan the whole queue through the single job memory read port, one
// entry a cycle, and swap the job with the least remaining time to the front.
// Items are processed one at a time: s_tready is high only while the sequencer is idle.
// The job memory holds LEVELS*QUEUE_DEPTH entries with one write and one
// registered read port; each level is a circular buffer (head, count).
// Reset clears counts, heads, elapsed time and next_level; no memory sweep.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds before the next result.
module multilevel_queue_scheduler_unit
	import mqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // job_id[7:0], burst[23:8], level[26:24], zero fill
	input  logic [0:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // job_id_res, finish_time, wait_time, served_level, zero fill
	output logic [2:0]  m_tuser,  // kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata
);

	localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SUB   = 9'b000000010,
		ST_LOOP  = 9'b000000100,
		ST_SCAN  = 9'b000001000,
		ST_SWAP  = 9'b000010000,
		ST_FRONT = 9'b000100000,
		ST_RUN   = 9'b001000000,
		ST_DONE  = 9'b010000000,
		ST_END   = 9'b100000000
	} state_t;

	// slot of logical position o in a circular queue starting at h
	function automatic logic [SW-1:0] wrap_pos(logic [SW-1:0] h, logic [CW-1:0] o);
		logic [SW+1:0] s;
		s = (SW+2)'(h) + (SW+2)'(o);
		if (s >= (SW+2)'(QUEUE_DEPTH))
			s = s - (SW+2)'(QUEUE_DEPTH);
		return s[SW-1:0];
	endfunction

	function automatic logic [AW-1:0] mem_addr(logic [LVL_W-1:0] l, logic [SW-1:0] p);
		return AW'(l) * AW'(QUEUE_DEPTH) + AW'(p);
	endfunction

	state_t state_q;
	logic [15:0] quantum_q;
	logic [5:0] budget_cfg_q;
	logic [CW-1:0] count_q [LEVELS];
	logic [SW-1:0] head_q [LEVELS];
	logic [31:0] elapsed_q;
	logic [LVL_W-1:0] next_lvl_q;

	// latched input item
	logic [7:0] id_q;
	logic [15:0] burst_in_q;
	logic bad_lvl_q;
	logic [LVL_W-1:0] lv_q;
	logic found_q;
	logic [5:0] budget_q;

	// job being worked on and scan state
	ent_t cur_q, front_q, best_ent_q;
	logic [CW-1:0] idx_q, best_idx_q;

	// job memory
	ent_t mem [LEVELS * QUEUE_DEPTH];
	ent_t rd_q;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	ent_t wr_data;

	// output register
	logic m_tvalid_q;
	logic emit_ok;
	logic emit_now;

	// decoded input fields
	logic [7:0] in_id;
	logic [15:0] in_burst;
	logic [2:0] in_level;
	assign in_id = s_tdata[7:0];
	assign in_burst = s_tdata[23:8];
	assign in_level = s_tdata[26:24];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign emit_ok = !m_tvalid_q || m_tready;
	assign emit_now = emit_ok && (state_q inside {ST_SUB, ST_DONE, ST_END});

	// level search for a run transaction
	logic sel_found;
	logic [LVL_W-1:0] sel_lvl;
	always_comb begin
		logic [LVL_W-1:0] c;
		sel_found = 1'b0;
		sel_lvl = next_lvl_q;
		for (int i = 0; i < LEVELS; i++) begin
			c = next_lvl_q + LVL_W'(i);
			if (!sel_found && count_q[c] != '0) begin
				sel_found = 1'b1;
				sel_lvl = c;
			end
		end
	end

	// current level view
	logic [CW-1:0] cnt;
	logic [SW-1:0] head;
	logic [CW-1:0] idx_nxt;
	assign cnt = count_q[lv_q];
	assign head = head_q[lv_q];
	assign idx_nxt = idx_q + CW'(1);

	// run step arithmetic
	logic [15:0] q_eff;
	logic rotate;
	logic [5:0] t_run;
	logic [15:0] add_amt;
	logic [32:0] sum_el;
	logic [31:0] el_nxt;
	logic [15:0] new_rem;
	logic [31:0] wait_val;
	assign q_eff = (quantum_q == '0) ? 16'd1 : quantum_q;
	assign rotate = (lv_q == '0) && (16'(budget_q) >= q_eff) && (cur_q.rem > q_eff);
	assign t_run = (cur_q.rem < 16'(budget_q)) ? cur_q.rem[5:0] : budget_q;
	assign add_amt = rotate ? q_eff : 16'(t_run);
	assign sum_el = {1'b0, elapsed_q} + 33'(add_amt);
	assign el_nxt = sum_el[32] ? 32'hFFFF_FFFF : sum_el[31:0];
	assign new_rem = cur_q.rem - 16'(t_run);
	assign wait_val = (elapsed_q >= 32'(cur_q.burst)) ? elapsed_q - 32'(cur_q.burst) : '0;

	// memory port control
	always_comb begin
		rd_addr = mem_addr(lv_q, head);
		if (state_q == ST_SCAN)
			rd_addr = mem_addr(lv_q, wrap_pos(head, idx_nxt));
		wr_en = 1'b0;
		wr_addr = mem_addr(lv_q, wrap_pos(head, cnt));
		wr_data = cur_q;
		case (state_q)
			ST_SUB: begin
				wr_en = emit_ok && !bad_lvl_q && cnt != CW'(QUEUE_DEPTH) && burst_in_q != '0;
				wr_data = '{id: id_q, burst: burst_in_q, rem: burst_in_q};
			end
			ST_SWAP: begin
				wr_en = (best_idx_q != '0);
				wr_addr = mem_addr(lv_q, wrap_pos(head, best_idx_q));
				wr_data = front_q;
			end
			ST_RUN: begin
				if (rotate) begin
					wr_en = 1'b1;
					wr_data.rem = cur_q.rem - q_eff;
				end else if (new_rem != '0) begin
					wr_en = 1'b1;
					wr_addr = mem_addr(lv_q, head);
					wr_data.rem = new_rem;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= RESET_QUANTUM;
			budget_cfg_q <= RESET_BUDGET;
		end else if (cfg_we) begin
			if (cfg_idx == REG_QUANTUM)
				quantum_q <= cfg_wdata;
			else
				budget_cfg_q <= cfg_wdata[5:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			id_q <= in_id;
			burst_in_q <= in_burst;
			bad_lvl_q <= in_level[2];
			lv_q <= (s_tuser[0] == OP_RUN) ? sel_lvl : in_level[LVL_W-1:0];
			found_q <= sel_found;
		end
		case (state_q)
			ST_SCAN: begin
				if (idx_q == '0) begin
					front_q <= rd_q;
					best_ent_q <= rd_q;
					best_idx_q <= '0;
				end else if (rd_q.rem < best_ent_q.rem) begin
					best_ent_q <= rd_q;
					best_idx_q <= idx_q;
				end
			end
			ST_SWAP: cur_q <= best_ent_q;
			ST_FRONT: cur_q <= rd_q;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < LEVELS; i++) begin
				count_q[i] <= '0;
				head_q[i] <= '0;
			end
			elapsed_q <= '0;
			next_lvl_q <= '0;
			budget_q <= '0;
			idx_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata <= '0;
			m_tuser <= '0;
			m_tlast <= 1'b0;
		end else begin
			if (m_tready && !emit_now)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						budget_q <= budget_cfg_q;
						if (s_tuser[0] == OP_SUBMIT)
							state_q <= ST_SUB;
						else if (sel_found)
							state_q <= ST_LOOP;
						else
							state_q <= ST_END;
					end
				end
				ST_SUB: begin
					if (emit_ok) begin
						m_tvalid_q <= 1'b1;
						m_tlast <= 1'b1;
						m_tdata <= {72'd0, id_q};
						if (bad_lvl_q)
							m_tuser <= KIND_BAD_LEVEL;
						else if (cnt == CW'(QUEUE_DEPTH))
							m_tuser <= KIND_QUEUE_FULL;
						else if (burst_in_q == '0)
							m_tuser <= KIND_ZERO_BURST;
						else begin
							m_tuser <= KIND_ACCEPTED;
							count_q[lv_q] <= cnt + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_LOOP: begin
					idx_q <= '0;
					if (budget_q == '0 || cnt == '0)
						state_q <= ST_END;
					else if (lv_q == 2'd1 || lv_q == 2'd2)
						state_q <= ST_SCAN;
					else
						state_q <= ST_FRONT;
				end
				ST_SCAN: begin
					if (idx_nxt < cnt)
						idx_q <= idx_nxt;
					else
						state_q <= ST_SWAP;
				end
				ST_SWAP: state_q <= ST_RUN;
				ST_FRONT: state_q <= ST_RUN;
				ST_RUN: begin
					elapsed_q <= el_nxt;
					if (rotate) begin
						head_q[lv_q] <= wrap_pos(head, CW'(1));
						budget_q <= budget_q - q_eff[5:0];
						state_q <= ST_LOOP;
					end else begin
						budget_q <= budget_q - t_run;
						state_q <= (new_rem == '0) ? ST_DONE : ST_LOOP;
					end
				end
				ST_DONE: begin
					if (emit_ok) begin
						m_tvalid_q <= 1'b1;
						m_tlast <= 1'b0;
						m_tuser <= KIND_COMPLETED;
						m_tdata <= {6'd0, lv_q, wait_val, elapsed_q, cur_q.id};
						head_q[lv_q] <= wrap_pos(head, CW'(1));
						count_q[lv_q] <= cnt - CW'(1);
						state_q <= ST_LOOP;
					end
				end
				ST_END: begin
					if (emit_ok) begin
						m_tvalid_q <= 1'b1;
						m_tlast <= 1'b1;
						m_tuser <= KIND_SLICE_END;
						m_tdata <= {6'd0, lv_q, 32'd0, elapsed_q, 8'd0};
						if (found_q)
							next_lvl_q <= lv_q + LVL_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// testbench of the multilevel queue scheduler: directed and random jobs checked against a predictor
module tb_top;
	import mqs_pkg::*;

	localparam int QDEPTH = 128;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] id;
		logic [31:0] fin;
		logic [31:0] wait_t;
		logic [1:0] lvl;
		logic last;
	} sched_res_t;

	typedef struct {
		logic [7:0] id;
		logic [15:0] burst;
		logic [15:0] rem;
	} job_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [79:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic cfg_we;
	logic cfg_idx;
	logic [15:0] cfg_wdata;

	// predictor state
	job_t job_q [4][$];
	logic [31:0] clock_now;
	logic [1:0] rr_level;
	logic [15:0] cur_quantum;
	logic [5:0] cur_budget;
	sched_res_t expected_q [$];

	int errors;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	multilevel_queue_scheduler_unit #(.QUEUE_DEPTH(QDEPTH)) uut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic void push_result(logic [2:0] kind, logic [7:0] id, logic [31:0] fin,
			logic [31:0] w, logic [1:0] lvl, logic last);
		sched_res_t r;
		r.kind = kind;
		r.id = id;
		r.fin = fin;
		r.wait_t = w;
		r.lvl = lvl;
		r.last = last;
		expected_q.push_back(r);
	endfunction

	// front job runs t units, completion reported when done
	function automatic logic [31:0] serve_front(int lv, logic [31:0] t);
		job_t f;
		logic [31:0] w;
		f = job_q[lv][0];
		clock_now = sat_add(clock_now, t);
		f.rem = (f.rem > t) ? f.rem - t[15:0] : 16'd0;
		job_q[lv][0] = f;
		if (f.rem == 0) begin
			w = (clock_now >= f.burst) ? clock_now - 32'(f.burst) : 32'd0;
			push_result(KIND_COMPLETED, f.id, clock_now, w, lv[1:0], 1'b0);
			void'(job_q[lv].pop_front());
		end
		return t;
	endfunction

	// expected results of one input transaction
	function automatic void predict_schedule(logic op, logic [7:0] id, logic [15:0] burst,
			logic [2:0] lvl);
		logic [2:0] kind;
		job_t j;
		job_t t;
		int lv;
		int best;
		bit found;
		logic [31:0] budget;
		logic [31:0] q;
		if (op == OP_SUBMIT) begin
			if (lvl > 3) kind = KIND_BAD_LEVEL;
			else if (job_q[lvl].size() >= QDEPTH) kind = KIND_QUEUE_FULL;
			else if (burst == 0) kind = KIND_ZERO_BURST;
			else begin
				j.id = id;
				j.burst = burst;
				j.rem = burst;
				job_q[lvl].push_back(j);
				kind = KIND_ACCEPTED;
			end
			push_result(kind, id, 32'd0, 32'd0, 2'd0, 1'b1);
			return;
		end
		lv = int'(rr_level);
		found = 0;
		for (int i = 0; i < 4; i++) begin
			if (!found && job_q[(rr_level + i) % 4].size() > 0) begin
				lv = (rr_level + i) % 4;
				found = 1;
			end
		end
		if (!found) begin
			push_result(KIND_SLICE_END, 8'd0, clock_now, 32'd0, rr_level, 1'b1);
			return;
		end
		budget = 32'(cur_budget);
		q = (cur_quantum == 0) ? 32'd1 : 32'(cur_quantum);
		while (budget != 0 && job_q[lv].size() > 0) begin
			if (lv == 0 && budget >= q) begin
				if (job_q[0][0].rem > q) begin
					t = job_q[0].pop_front();
					budget -= q;
					clock_now = sat_add(clock_now, q);
					t.rem -= q[15:0];
					job_q[0].push_back(t);
				end else begin
					budget -= serve_front(0, 32'(job_q[0][0].rem));
				end
				continue;
			end
			if (lv == 1 || lv == 2) begin
				best = 0;
				for (int i = 1; i < job_q[lv].size(); i++)
					if (job_q[lv][i].rem < job_q[lv][best].rem) best = i;
				t = job_q[lv][0];
				job_q[lv][0] = job_q[lv][best];
				job_q[lv][best] = t;
			end
			if (job_q[lv][0].rem <= budget) begin
				budget -= serve_front(lv, 32'(job_q[lv][0].rem));
			end else begin
				void'(serve_front(lv, budget));
				budget = 0;
			end
		end
		push_result(KIND_SLICE_END, 8'd0, clock_now, 32'd0, lv[1:0], 1'b1);
		rr_level = lv[1:0] + 2'd1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected transaction", {29'd0, m_tuser}, 32'd0);
				end else begin
					e = expected_q.pop_front();
					if (m_tuser !== e.kind)
						report_mismatch("kind", 32'(m_tuser), 32'(e.kind));
					if (m_tdata[7:0] !== e.id)
						report_mismatch("job_id", 32'(m_tdata[7:0]), 32'(e.id));
					if (m_tdata[39:8] !== e.fin) report_mismatch("finish", m_tdata[39:8], e.fin);
					if (m_tdata[71:40] !== e.wait_t)
						report_mismatch("wait", m_tdata[71:40], e.wait_t);
					if (m_tdata[73:72] !== e.lvl)
						report_mismatch("level", 32'(m_tdata[73:72]), 32'(e.lvl));
					if (m_tlast !== e.last)
						report_mismatch("last", 32'(m_tlast), 32'(e.last));
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// valid stays high after a transaction until the next idle cycle or drain
	task automatic send_item(logic op, logic [7:0] id, logic [15:0] burst, logic [2:0] lvl);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, lvl, burst, id};
		predict_schedule(op, id, burst, lvl);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_QUANTUM) cur_quantum = val;
		else cur_budget = val[5:0];
	endtask

	task automatic submit(logic [7:0] id, logic [15:0] burst, logic [2:0] lvl);
		send_item(OP_SUBMIT, id, burst, lvl);
	endtask

	task automatic run_slice;
		send_item(OP_RUN, 8'($urandom), 16'($urandom), 3'($urandom));
	endtask

	// field extremes, rejects, empty run and each level policy
	task automatic test_directed;
		run_slice();
		submit(8'hFF, 16'd5, 3'd7);
		submit(8'h00, 16'd0, 3'd2);
		submit(8'h01, 16'd3, 3'd0);
		submit(8'h02, 16'd9, 3'd0);
		submit(8'h03, 16'd7, 3'd1);
		submit(8'h04, 16'd2, 3'd1);
		submit(8'h05, 16'd2, 3'd2);
		submit(8'h06, 16'hFFFF, 3'd3);
		submit(8'hAA, 16'd1, 3'd4);
		repeat (6) run_slice();
		write_reg(REG_QUANTUM, 16'd0);
		write_reg(REG_BUDGET, 16'd63);
		submit(8'h10, 16'd3, 3'd0);
		submit(8'h11, 16'd2, 3'd0);
		repeat (4) run_slice();
		write_reg(REG_QUANTUM, 16'hFFFF);
		write_reg(REG_BUDGET, 16'd1);
		submit(8'h12, 16'd4, 3'd0);
		repeat (3) run_slice();
	endtask

	// fill one level to reject with queue full, then run it with full and zero budget
	task automatic test_queue_full;
		write_reg(REG_BUDGET, 16'd63);
		for (int i = 0; i <= QDEPTH; i++) submit(i[7:0], 16'd1, 3'd3);
		repeat (8) run_slice();
		write_reg(REG_BUDGET, 16'd0);
		run_slice();
	endtask

	// random mix of submits and runs under one setting
	task automatic test_random(int n, logic [15:0] q, logic [5:0] b, int idle, int stall);
		int pick;
		write_reg(REG_QUANTUM, q);
		write_reg(REG_BUDGET, {10'd0, b});
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				submit(8'($urandom), 16'($urandom_range(1, 40)), 3'($urandom_range(0, 3)));
			else if (pick < 50) submit(8'($urandom), 16'($urandom), 3'($urandom));
			else run_slice();
		end
	endtask

	// large bursts drive the elapsed time far up
	task automatic test_long_bursts;
		write_reg(REG_BUDGET, 16'd63);
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < 12; i++) begin
			submit(8'($urandom), 16'(32'hFFFF - $urandom_range(3)), 3'd3);
			submit(8'($urandom), 16'(32'h8000 | $urandom), 3'd1);
		end
		repeat (20) run_slice();
	endtask

	initial begin
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		clock_now = 0;
		rr_level = 0;
		cur_quantum = RESET_QUANTUM;
		cur_budget = RESET_BUDGET;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_idx = REG_QUANTUM;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_queue_full();
		test_random(52, 16'd4, 6'd20, 0, 0);
		test_random(50, 16'd1, 6'd63, 76, 0);
		test_random(50, 16'd7, 6'd1, 0, 76);
		test_random(50, 16'd3, 6'd33, 19, 19);
		test_long_bursts();
		drain();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
